>>> rtl/core/hufd_pkg.sv
// Shared types and constants for the tree decoder core.
// Used by hufd_front, hufd_back and huffman_tree_decoder_core; depends on nothing.
package hufd_pkg;

  localparam int NODE_CAPACITY = 512;
  localparam int LONGEST_CODE  = 32;

  localparam int NODE_W     = $clog2(NODE_CAPACITY);
  localparam int NCNT_W     = $clog2(NODE_CAPACITY + 1);
  localparam int NCHK_W     = NCNT_W + 1;
  localparam int SYM_W      = 8;
  localparam int LEN_W      = 6;
  localparam int CODE_W     = 32;
  localparam int CODE_IX_W  = $clog2(CODE_W);
  localparam int OP_W       = 2;
  localparam int COUNT_W    = 32;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_DECODE = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic              bit_in;
  } item_t;

endpackage

>>> rtl/core/hufd_front.sv
// Front end: accepts input words, drops opcode 3 and overlong load words, queues the rest.
// Depends on hufd_pkg.
module hufd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hufd_pkg::OP_W-1:0]     in_opcode,
  input  logic [hufd_pkg::SYM_W-1:0]    in_entry_symbol,
  input  logic [hufd_pkg::LEN_W-1:0]    in_code_length,
  input  logic [hufd_pkg::CODE_W-1:0]   in_code_value,
  input  logic                          in_data_bit,
  output logic                          q_valid,
  output hufd_pkg::item_t               q_item,
  input  logic                          q_pop
);

  hufd_pkg::item_t                  q_mem_r [hufd_pkg::Q_DEPTH];
  logic [hufd_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [hufd_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [hufd_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;
  hufd_pkg::item_t                  cls_item;
  logic                             keep;
  logic                             push;
  logic                             pop;

  always_comb begin
    cls_item.sym    = in_entry_symbol;
    cls_item.len    = in_code_length;
    cls_item.code   = in_code_value;
    cls_item.bit_in = in_data_bit;
    cls_item.kind   = hufd_pkg::KIND_CLEAR;
    keep            = 1'b0;
    case (in_opcode)
      hufd_pkg::OP_CLEAR: begin
        cls_item.kind = hufd_pkg::KIND_CLEAR;
        keep          = 1'b1;
      end
      hufd_pkg::OP_LOAD: begin
        cls_item.kind = hufd_pkg::KIND_LOAD;
        keep = ({1'b0, in_code_length} <= (hufd_pkg::LEN_W + 1)'(hufd_pkg::LONGEST_CODE));
      end
      hufd_pkg::OP_DECODE: begin
        cls_item.kind = hufd_pkg::KIND_DECODE;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (cnt_r == hufd_pkg::Q_CNT_W'(hufd_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

>>> rtl/core/hufd_back.sv
// Back end: node memories, load and decode sequencer, result register.
// Depends on hufd_pkg; fed by hufd_front.
module hufd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  hufd_pkg::item_t                q_item,
  output logic                           q_pop,
  input  logic [hufd_pkg::COUNT_W-1:0]   target,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hufd_pkg::SYM_W-1:0]     out_decoded_byte,
  output logic                           out_final_symbol
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_L_STEP = 4'd1;
  localparam logic [3:0] S_L_NEXT = 4'd2;
  localparam logic [3:0] S_L_CHK  = 4'd3;
  localparam logic [3:0] S_L_NEW  = 4'd4;
  localparam logic [3:0] S_L_LINK = 4'd5;
  localparam logic [3:0] S_L_SYM  = 4'd6;
  localparam logic [3:0] S_D_PICK = 4'd7;
  localparam logic [3:0] S_D_EMIT = 4'd8;

  logic [hufd_pkg::NODE_W-1:0] left_mem  [hufd_pkg::NODE_CAPACITY];
  logic [hufd_pkg::NODE_W-1:0] right_mem [hufd_pkg::NODE_CAPACITY];
  logic [hufd_pkg::SYM_W-1:0]  sym_mem   [hufd_pkg::NODE_CAPACITY];

  logic [3:0]                      state_r, state_nxt;
  logic [hufd_pkg::NCNT_W-1:0]     nodes_r, nodes_nxt;
  logic [hufd_pkg::NODE_W-1:0]     walk_r, walk_nxt;
  logic [hufd_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic                            root_l_r, root_l_nxt;
  logic                            root_r_r, root_r_nxt;
  logic [hufd_pkg::NODE_W-1:0]     n_r, n_nxt;
  logic [hufd_pkg::LEN_W-1:0]      depth_r, depth_nxt;
  logic [hufd_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [hufd_pkg::SYM_W-1:0]      sym_r, sym_nxt;
  logic [hufd_pkg::CODE_W-1:0]     code_r, code_nxt;
  logic                            bit_r, bit_nxt;
  logic                            short_r, short_nxt;
  logic [hufd_pkg::NODE_W-1:0]     next_r, next_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic [hufd_pkg::SYM_W-1:0]      out_byte_r, out_byte_nxt;
  logic                            out_fin_r, out_fin_nxt;

  logic [hufd_pkg::NODE_W-1:0]     rd_addr;
  logic [hufd_pkg::NODE_W-1:0]     rd_l_r, rd_r_r;
  logic [hufd_pkg::SYM_W-1:0]      rd_s_r;

  logic                            wl_en, wr_en, ws_en;
  logic [hufd_pkg::NODE_W-1:0]     wl_addr, wr_addr, ws_addr;
  logic [hufd_pkg::NODE_W-1:0]     wl_data, wr_data;
  logic [hufd_pkg::SYM_W-1:0]      ws_data;

  logic [hufd_pkg::LEN_W-1:0]      bit_pos;
  logic                            path_bit;
  logic [hufd_pkg::NODE_W-1:0]     child;
  logic [hufd_pkg::LEN_W-1:0]      needed;
  logic [hufd_pkg::NCHK_W-1:0]     nodes_after;
  logic                            root_full;
  logic                            is_leaf;
  logic                            slot_free;
  logic [hufd_pkg::COUNT_W-1:0]    count_inc;

  assign bit_pos     = len_r - depth_r - 1'b1;
  assign path_bit    = code_r[bit_pos[hufd_pkg::CODE_IX_W-1:0]];
  assign needed      = len_r - depth_r;
  assign nodes_after = {1'b0, nodes_r} + hufd_pkg::NCHK_W'(needed);
  assign root_full   = root_l_r && root_r_r;
  assign slot_free   = !out_vld_r || !out_stall;
  assign count_inc   = count_r + 1'b1;
  assign is_leaf     = (next_r == '0) ? !root_full : (rd_l_r == '0 || rd_r_r == '0);

  always_comb begin
    if (n_r == '0) begin
      child = path_bit ? (root_r_r ? rd_r_r : '0) : (root_l_r ? rd_l_r : '0);
    end else begin
      child = path_bit ? rd_r_r : rd_l_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    nodes_nxt    = nodes_r;
    walk_nxt     = walk_r;
    count_nxt    = count_r;
    root_l_nxt   = root_l_r;
    root_r_nxt   = root_r_r;
    n_nxt        = n_r;
    depth_nxt    = depth_r;
    len_nxt      = len_r;
    sym_nxt      = sym_r;
    code_nxt     = code_r;
    bit_nxt      = bit_r;
    short_nxt    = short_r;
    next_nxt     = next_r;
    out_byte_nxt = out_byte_r;
    out_fin_nxt  = out_fin_r;
    out_vld_nxt  = out_vld_r && out_stall;
    q_pop        = 1'b0;
    rd_addr      = walk_r;
    wl_en        = 1'b0;
    wr_en        = 1'b0;
    ws_en        = 1'b0;
    wl_addr      = n_r;
    wr_addr      = n_r;
    ws_addr      = n_r;
    wl_data      = '0;
    wr_data      = '0;
    ws_data      = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          len_nxt  = q_item.len;
          sym_nxt  = q_item.sym;
          code_nxt = q_item.code;
          bit_nxt  = q_item.bit_in;
          case (q_item.kind)
            hufd_pkg::KIND_CLEAR: begin
              wl_en      = 1'b1;
              wr_en      = 1'b1;
              ws_en      = 1'b1;
              wl_addr    = '0;
              wr_addr    = '0;
              ws_addr    = '0;
              nodes_nxt  = hufd_pkg::NCNT_W'(1);
              walk_nxt   = '0;
              count_nxt  = '0;
              root_l_nxt = 1'b0;
              root_r_nxt = 1'b0;
            end
            hufd_pkg::KIND_LOAD: begin
              n_nxt     = '0;
              depth_nxt = '0;
              state_nxt = S_L_STEP;
            end
            hufd_pkg::KIND_DECODE: begin
              if (count_r < target) begin
                short_nxt = (walk_r == '0) && !root_full;
                state_nxt = S_D_PICK;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_L_STEP: begin
        rd_addr = n_r;
        state_nxt = (depth_r == len_r) ? S_L_CHK : S_L_NEXT;
      end
      S_L_NEXT: begin
        if (child == '0) begin
          state_nxt = S_L_CHK;
        end else begin
          n_nxt     = child;
          depth_nxt = depth_r + 1'b1;
          state_nxt = S_L_STEP;
        end
      end
      S_L_CHK: begin
        if (nodes_after > hufd_pkg::NCHK_W'(hufd_pkg::NODE_CAPACITY)) begin
          state_nxt = S_IDLE;
        end else if (depth_r == len_r) begin
          state_nxt = S_L_SYM;
        end else begin
          state_nxt = S_L_NEW;
        end
      end
      S_L_NEW: begin
        wl_en     = 1'b1;
        wr_en     = 1'b1;
        ws_en     = 1'b1;
        wl_addr   = nodes_r[hufd_pkg::NODE_W-1:0];
        wr_addr   = nodes_r[hufd_pkg::NODE_W-1:0];
        ws_addr   = nodes_r[hufd_pkg::NODE_W-1:0];
        state_nxt = S_L_LINK;
      end
      S_L_LINK: begin
        wl_data = nodes_r[hufd_pkg::NODE_W-1:0];
        wr_data = nodes_r[hufd_pkg::NODE_W-1:0];
        if (path_bit) begin
          wr_en = 1'b1;
          if (n_r == '0) begin
            root_r_nxt = 1'b1;
          end
        end else begin
          wl_en = 1'b1;
          if (n_r == '0) begin
            root_l_nxt = 1'b1;
          end
        end
        n_nxt     = nodes_r[hufd_pkg::NODE_W-1:0];
        nodes_nxt = nodes_r + 1'b1;
        depth_nxt = depth_r + 1'b1;
        state_nxt = (depth_r + 1'b1 == len_r) ? S_L_SYM : S_L_NEW;
      end
      S_L_SYM: begin
        ws_en     = 1'b1;
        ws_data   = sym_r;
        state_nxt = S_IDLE;
      end
      S_D_PICK: begin
        next_nxt  = short_r ? '0 : (bit_r ? rd_r_r : rd_l_r);
        rd_addr   = next_nxt;
        state_nxt = S_D_EMIT;
      end
      S_D_EMIT: begin
        rd_addr = next_r;
        if (!is_leaf) begin
          walk_nxt  = next_r;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_byte_nxt = rd_s_r;
          out_fin_nxt  = (count_inc == target);
          count_nxt    = count_inc;
          walk_nxt     = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wl_en) begin
      left_mem[wl_addr] <= wl_data;
    end
    if (wr_en) begin
      right_mem[wr_addr] <= wr_data;
    end
    if (ws_en) begin
      sym_mem[ws_addr] <= ws_data;
    end
    rd_l_r <= left_mem[rd_addr];
    rd_r_r <= right_mem[rd_addr];
    rd_s_r <= sym_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      nodes_r   <= hufd_pkg::NCNT_W'(1);
      walk_r    <= '0;
      count_r   <= '0;
      root_l_r  <= 1'b0;
      root_r_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      nodes_r   <= nodes_nxt;
      walk_r    <= walk_nxt;
      count_r   <= count_nxt;
      root_l_r  <= root_l_nxt;
      root_r_r  <= root_r_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    depth_r    <= depth_nxt;
    len_r      <= len_nxt;
    sym_r      <= sym_nxt;
    code_r     <= code_nxt;
    bit_r      <= bit_nxt;
    short_r    <= short_nxt;
    next_r     <= next_nxt;
    out_byte_r <= out_byte_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_decoded_byte = out_byte_r;
  assign out_final_symbol = out_fin_r;

endmodule

>>> rtl/core/huffman_tree_decoder_core.sv
// Top level of the code-tree decoder: symbol count register, front queue, back sequencer.
// Depends on hufd_pkg, hufd_front and hufd_back.
//
//   channel  | handshake           | word
//   in_      | in_valid / in_stall | opcode, entry_symbol, code_length, code_value, data_bit
//   out_     | out_valid/out_stall | decoded_byte, final_symbol
//   cfg_     | cfg_valid/cfg_ready | symbols_to_decode
//
// Decode word: node read, child read, then result (or walk kept if no leaf); dropped past the count.
// Load word: dispatch, step and child read per existing node walked, room check, write and link per
// new node, symbol write. Clear word: done at dispatch. Opcode 3 and overlong loads end in front.
// The two-entry queue takes words while the back works; in_stall rises when it is full.
// A result held by out_stall holds the back in its result cycle.
// Reset clears control state only; node memories hold garbage until written.
module huffman_tree_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hufd_pkg::OP_W-1:0]     in_opcode,
  input  logic [hufd_pkg::SYM_W-1:0]    in_entry_symbol,
  input  logic [hufd_pkg::LEN_W-1:0]    in_code_length,
  input  logic [hufd_pkg::CODE_W-1:0]   in_code_value,
  input  logic                          in_data_bit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hufd_pkg::SYM_W-1:0]    out_decoded_byte,
  output logic                          out_final_symbol,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hufd_pkg::COUNT_W-1:0]  cfg_symbols_to_decode
);

  logic [hufd_pkg::COUNT_W-1:0] target_r, target_nxt;
  logic                         q_valid;
  hufd_pkg::item_t              q_item;
  logic                         q_pop;

  assign cfg_ready  = 1'b1;
  assign target_nxt = (cfg_valid && cfg_ready) ? cfg_symbols_to_decode : target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else begin
      target_r <= target_nxt;
    end
  end

  hufd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_entry_symbol (in_entry_symbol),
    .in_code_length  (in_code_length),
    .in_code_value   (in_code_value),
    .in_data_bit     (in_data_bit),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  hufd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .target           (target_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_decoded_byte (out_decoded_byte),
    .out_final_symbol (out_final_symbol)
  );

endmodule
